// ===== rtl/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg
// Types and constants shared by the colorizer controller, datapath and top.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int PIX_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int ZOOM_W    = 31;
    localparam int COORD_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = LIMIT_W + 1;
    localparam int COLOR_W   = 8;
    localparam int FRAC_BITS = 28;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_STEP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IMAG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd3;

    localparam logic [ZOOM_W-1:0]         ZOOM_RST  = 31'd1048576;
    localparam logic signed [COORD_W-1:0] CREAL_RST = -32'sd134217728;
    localparam logic signed [COORD_W-1:0] CIMAG_RST = 32'sd0;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST = 16'd256;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    // 4.0 in the Q8.56 format of a product
    localparam logic [64:0]        ESC_LIMIT = 65'h0_0400_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_INIT,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_pix;
        logic map;
        logic init;
        logic mul;
        logic step;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic hit;
    } status_t;

endpackage

// ===== rtl/mpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpc_ctrl
// Sequencer for one pixel: coordinate mapping, the escape loop and output.
// ----------------------------------------------------------------------------
module mpc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    output logic             color_valid,
    input  logic             color_stall,
    input  mpc_pkg::status_t status,
    output mpc_pkg::cmd_t    cmd
);
    import mpc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || !color_stall;
    assign pixel_stall = (state_reg != ST_IDLE);
    assign color_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                    state_next = ST_MAP;
            end
            ST_MAP:  state_next = ST_INIT;
            ST_INIT: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:
            begin
                if (status.stop || status.hit)
                    state_next = ST_OUT;
                else
                    state_next = ST_MUL;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: cmd.load_pix = pixel_valid;
            ST_MAP:  cmd.map      = 1'b1;
            ST_INIT: cmd.init     = 1'b1;
            ST_MUL:  cmd.mul      = 1'b1;
            ST_ADD:
            begin
                if (status.stop || status.hit)
                    cmd.finish = 1'b1;
                else
                    cmd.step = 1'b1;
            end
            ST_OUT:  cmd.emit = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !color_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/mpc_datapath.sv =====
// ----------------------------------------------------------------------------
// mpc_datapath
// Configuration registers, coordinate mapping, z iteration and palette.
// ----------------------------------------------------------------------------
module mpc_datapath
#(
    parameter int IMAGE_W = 1024,
    parameter int IMAGE_H = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpc_pkg::CFG_W-1:0]           cfg_data,
    input  logic [mpc_pkg::PIX_W-1:0]           pixel_x,
    input  logic [mpc_pkg::PIX_W-1:0]           pixel_y,
    input  mpc_pkg::cmd_t                       cmd,
    output mpc_pkg::status_t                    status,
    output logic [mpc_pkg::COLOR_W-1:0]         red,
    output logic [mpc_pkg::COLOR_W-1:0]         green,
    output logic [mpc_pkg::COLOR_W-1:0]         blue,
    output logic                                inside_set,
    output logic [mpc_pkg::LIMIT_W-1:0]         escape_count
);
    import mpc_pkg::*;

    localparam int SZW_X = ($clog2(IMAGE_W + 1) > PIX_W + 1) ? $clog2(IMAGE_W + 1) : PIX_W + 1;
    localparam int SZW_Y = ($clog2(IMAGE_H + 1) > PIX_W + 1) ? $clog2(IMAGE_H + 1) : PIX_W + 1;
    localparam int TWX   = SZW_X + 1;
    localparam int TWY   = SZW_Y + 1;
    localparam logic signed [TWX-1:0] SIZE_X = TWX'(IMAGE_W);
    localparam logic signed [TWY-1:0] SIZE_Y = TWY'(IMAGE_H);

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[COORD_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [3*COLOR_W-1:0] palette(input logic [LIMIT_W-1:0] n);
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        r = '0;
        g = '0;
        b = '0;
        if (n == '0)
        begin
            r = 8'd255;
        end
        else if (n < 16'd16)
        begin
            r = 8'(9'd256 - {1'b0, n[3:0], 4'b0000});
            b = {n[3:0], 4'b0000} - 8'd1;
        end
        else if (n < 16'd32)
        begin
            g = {n[3:0], 4'b0000};
            b = 8'(9'd511 - {n[4:0], 4'b0000});
        end
        else if (n < 16'd64)
        begin
            r = {n[4:0], 3'b000};
            g = 8'(9'd511 - {n[5:0], 3'b000});
        end
        else
        begin
            // last band wraps modulo 256
            r = 8'd255 - {n[5:0], 2'b00};
        end
        return {r, g, b};
    endfunction

    // configuration
    logic [ZOOM_W-1:0]         zoom_reg;
    logic signed [COORD_W-1:0] creal_reg;
    logic signed [COORD_W-1:0] cimag_reg;
    logic [LIMIT_W-1:0]        limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg  <= ZOOM_RST;
            creal_reg <= CREAL_RST;
            cimag_reg <= CIMAG_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ZOOM_STEP:       zoom_reg  <= cfg_data[ZOOM_W-1:0];
                CFG_CENTER_REAL:     creal_reg <= $signed(cfg_data);
                CFG_CENTER_IMAG:     cimag_reg <= $signed(cfg_data);
                CFG_ITERATION_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:             limit_reg <= limit_reg;
            endcase
        end
    end

    // payload
    logic [PIX_W-1:0]          px_reg;
    logic [PIX_W-1:0]          py_reg;
    logic signed [TWX+31:0]    prod_x_reg;
    logic signed [TWY+31:0]    prod_y_reg;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] zr_reg;
    logic signed [COORD_W-1:0] zi_reg;
    logic signed [63:0]        sr_reg;
    logic signed [63:0]        si_reg;
    logic signed [63:0]        cross_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      hit_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;
    logic                      inside_reg;
    logic [LIMIT_W-1:0]        escape_reg;

    logic signed [TWX-1:0]     twice_x;
    logic signed [TWY-1:0]     twice_y;
    logic signed [31:0]        zoom_s;
    logic signed [TWX+31:0]    prod_x;
    logic signed [TWY+31:0]    prod_y;
    logic signed [63:0]        map_x_sum;
    logic signed [63:0]        map_y_sum;
    logic [64:0]               mag;
    logic signed [63:0]        diff;
    logic signed [63:0]        nr_sum;
    logic signed [63:0]        ni_sum;
    logic signed [COORD_W-1:0] nr;
    logic signed [COORD_W-1:0] ni;
    logic                      over;
    logic                      inside_fin;
    logic [LIMIT_W-1:0]        n_fin;
    logic [3*COLOR_W-1:0]      rgb;

    assign twice_x   = $signed(TWX'({px_reg, 1'b0})) - SIZE_X;
    assign twice_y   = $signed(TWY'({py_reg, 1'b0})) - SIZE_Y;
    assign zoom_s    = $signed({1'b0, zoom_reg});
    assign prod_x    = twice_x * zoom_s;
    assign prod_y    = twice_y * zoom_s;
    assign map_x_sum = 64'(prod_x_reg >>> 1) + 64'(creal_reg);
    assign map_y_sum = 64'(prod_y_reg >>> 1) + 64'(cimag_reg);

    assign mag    = {1'b0, sr_reg} + {1'b0, si_reg};
    assign over   = count_reg > {1'b0, limit_reg};
    assign diff   = sr_reg - si_reg;
    assign nr_sum = (diff >>> FRAC_BITS) + 64'(cr_reg);
    assign ni_sum = (cross_reg >>> (FRAC_BITS - 1)) + 64'(ci_reg);
    assign nr     = sat32(nr_sum);
    assign ni     = sat32(ni_sum);

    assign status.stop = (mag > ESC_LIMIT) || over;
    assign status.hit  = (nr == cr_reg) && (ni == ci_reg);

    assign inside_fin = hit_reg || (count_reg >= {1'b0, limit_reg});
    assign n_fin      = inside_fin ? '0 : count_reg[LIMIT_W-1:0];
    assign rgb        = inside_fin ? '0 : palette(n_fin);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map)
        begin
            prod_x_reg <= prod_x;
            prod_y_reg <= prod_y;
        end
        if (cmd.init)
        begin
            cr_reg    <= sat32(map_x_sum);
            ci_reg    <= sat32(map_y_sum);
            zr_reg    <= sat32(map_x_sum);
            zi_reg    <= sat32(map_y_sum);
            count_reg <= '0;
        end
        if (cmd.mul)
        begin
            sr_reg    <= zr_reg * zr_reg;
            si_reg    <= zi_reg * zi_reg;
            cross_reg <= zr_reg * zi_reg;
        end
        if (cmd.step)
        begin
            zr_reg    <= nr;
            zi_reg    <= ni;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.finish)
            hit_reg <= status.hit && !status.stop;
        if (cmd.emit)
        begin
            red_reg    <= rgb[3*COLOR_W-1:2*COLOR_W];
            green_reg  <= rgb[2*COLOR_W-1:COLOR_W];
            blue_reg   <= rgb[COLOR_W-1:0];
            inside_reg <= inside_fin;
            escape_reg <= n_fin;
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign inside_set   = inside_reg;
    assign escape_count = escape_reg;

endmodule

// ===== rtl/mandelbrot_pixel_colorizer.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer
// Escape-time colorizer: maps a pixel to c, iterates z = z^2 + c, colors it.
// ----------------------------------------------------------------------------
// from accept to result valid: map, init, k loop passes (k <= limit + 2), then output
// each square-and-add pass: 32x32 products, then add and saturate
// one pixel in flight; the next is taken once the result is in the output register
// reset clears the sequencer and output valid and loads the default window and limit
module mandelbrot_pixel_colorizer
#(
    parameter int IMAGE_W = 1024,
    parameter int IMAGE_H = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [mpc_pkg::PIX_W-1:0]       pixel_x,
    input  logic [mpc_pkg::PIX_W-1:0]       pixel_y,
    output logic                            color_valid,
    input  logic                            color_stall,
    output logic [mpc_pkg::COLOR_W-1:0]     red,
    output logic [mpc_pkg::COLOR_W-1:0]     green,
    output logic [mpc_pkg::COLOR_W-1:0]     blue,
    output logic                            inside_set,
    output logic [mpc_pkg::LIMIT_W-1:0]     escape_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpc_pkg::CFG_W-1:0]       cfg_data
);
    import mpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mpc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .status      (status),
        .cmd         (cmd)
    );

    mpc_datapath
    #(
        .IMAGE_W (IMAGE_W),
        .IMAGE_H (IMAGE_H)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cmd          (cmd),
        .status       (status),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .inside_set   (inside_set),
        .escape_count (escape_count)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-time colorizer. Pixels go in through a
// bursty driver; every accepted pixel is run through a Q4.28 escape-time
// model and its color is checked against the result seen at the output.
// ----------------------------------------------------------------------------
module tb;
    import mpc_pkg::*;

    localparam int              FRAC         = 28;
    localparam longint unsigned ESCAPE_R2    = 64'd1 << 58;
    localparam longint          Q_MAX        = 64'sd2147483647;
    localparam longint          Q_MIN        = -64'sd2147483648;
    localparam int              IMG_W        = 1024;
    localparam int              IMG_H        = 1024;
    localparam int              RAND_PHASES  = 10;
    localparam int              RAND_ITEMS   = 123;
    localparam int              MAX_GAP      = 12;
    localparam int              MAX_STALL    = 12;
    localparam int              HOLD_LEN     = 2500;
    localparam int              DRAIN_CYCLES = 700;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               in_set;
        logic [LIMIT_W-1:0] esc;
    } color_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_stall;
    logic [PIX_W-1:0]     pixel_x      = '0;
    logic [PIX_W-1:0]     pixel_y      = '0;
    logic                 color_valid;
    logic                 color_stall  = 1'b0;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 inside_set;
    logic [LIMIT_W-1:0]   escape_count;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    // window and limit as the block should hold them
    logic [ZOOM_W-1:0]         zoom_q = 31'd1048576;
    logic signed [COORD_W-1:0] cre_q  = -32'sd134217728;
    logic signed [COORD_W-1:0] cim_q  = 32'sd0;
    logic [LIMIT_W-1:0]        lim_q  = 16'd256;

    pixel_t pixel_q[$];
    color_t color_q[$];
    pixel_t next_pix;
    color_t want;
    logic   pix_acc      = 1'b0;
    int     burst_left   = 0;
    int     gap_left     = 0;
    int     stall_left   = 0;
    int     open_left    = 0;
    int     hold_left    = 0;
    int     hold_reqs    = 0;
    int     hold_seen    = 0;
    int     queued_cnt   = 0;
    int     color_cnt    = 0;
    int     fail_cnt     = 0;
    longint cycle_cnt    = 0;
    longint cycle_budget = 50000 + 4 * HOLD_LEN;

    mandelbrot_pixel_colorizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .color_valid  (color_valid),
        .color_stall  (color_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .inside_set   (inside_set),
        .escape_count (escape_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // (2*pix - span) * zoom / 2, floored, plus the center
    function automatic longint map_axis(input logic [PIX_W-1:0] pix, input int span,
                                        input longint ctr);
        longint prod;
        prod = (2 * longint'(pix) - span) * longint'(zoom_q);
        return sat32((prod >>> 1) + ctr);
    endfunction

    function automatic color_t colorize(input logic [PIX_W-1:0] px,
                                        input logic [PIX_W-1:0] py);
        longint          cr, ci, zr, zi, sr, si, nr, ni;
        longint unsigned r2;
        int unsigned     n;
        bit              in_set, done;
        color_t          c;
        cr     = map_axis(px, IMG_W, cre_q);
        ci     = map_axis(py, IMG_H, cim_q);
        zr     = cr;
        zi     = ci;
        n      = 0;
        in_set = 1'b0;
        done   = 1'b0;
        while (!done)
        begin
            sr = zr * zr;
            si = zi * zi;
            r2 = sr + si;
            if (r2 > ESCAPE_R2 || n > lim_q)
                done = 1'b1;
            else
            begin
                nr = sat32(((sr - si) >>> FRAC) + cr);
                ni = sat32(((zr * zi) >>> (FRAC - 1)) + ci);
                zr = nr;
                zi = ni;
                // orbit landed back on c
                if (zr == cr && zi == ci)
                begin
                    in_set = 1'b1;
                    done   = 1'b1;
                end
                else
                    n++;
            end
        end
        if (n >= lim_q)
            in_set = 1'b1;
        c        = '0;
        c.in_set = in_set;
        if (!in_set)
        begin
            c.esc = n[LIMIT_W-1:0];
            if (n == 0)
                c.red = 8'd255;
            else if (n < 16)
            begin
                c.red  = 8'(16 * (16 - n));
                c.blue = 8'(16 * n - 1);
            end
            else if (n < 32)
            begin
                c.green = 8'(16 * (n - 16));
                c.blue  = 8'(16 * (32 - n) - 1);
            end
            else if (n < 64)
            begin
                c.red   = 8'(8 * (n - 32));
                c.green = 8'(8 * (64 - n) - 1);
            end
            else
                c.red = 8'(255 - 4 * (n - 64));
        end
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        pixel_q.push_back('{x: x[PIX_W-1:0], y: y[PIX_W-1:0]});
        queued_cnt++;
        cycle_budget += 4 * (2 * (longint'(lim_q) + 2) + 5 + MAX_GAP + MAX_STALL + 8);
    endtask

    task automatic wait_drained();
        wait (color_cnt >= queued_cnt);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ZOOM_STEP:       zoom_q = val[ZOOM_W-1:0];
            CFG_CENTER_REAL:     cre_q  = val;
            CFG_CENTER_IMAG:     cim_q  = val;
            CFG_ITERATION_LIMIT: lim_q  = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits carry junk, the block must drop them
    task automatic set_window(input int unsigned zoom, input int cre, input int cim,
                              input int unsigned lim);
        wait_drained();
        write_reg(CFG_ZOOM_STEP, {1'($urandom_range(0, 1)), zoom[ZOOM_W-1:0]});
        write_reg(CFG_CENTER_REAL, cre);
        write_reg(CFG_CENTER_IMAG, cim);
        write_reg(CFG_ITERATION_LIMIT, {16'($urandom), lim[LIMIT_W-1:0]});
        @(posedge clk);
    endtask

    // pixel sender: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || pix_acc))
        begin
            if (pix_acc && burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            end
            if (gap_left > 0 || pixel_q.size() == 0)
            begin
                pixel_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                next_pix     = pixel_q.pop_front();
                pixel_x     <= next_pix.x;
                pixel_y     <= next_pix.y;
                pixel_valid <= 1'b1;
            end
        end
    end

    // color receiver: short stall runs, free stretches, and the long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            color_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            color_stall <= 1'b1;
            stall_left--;
        end
        else if (open_left > 0)
        begin
            color_stall <= 1'b0;
            open_left--;
        end
        else
        begin
            color_stall <= 1'b0;
            case ($urandom_range(0, 3))
                0:
                begin
                    stall_left = 0;
                    open_left  = $urandom_range(40, 200);
                end
                1:
                begin
                    stall_left = $urandom_range(1, MAX_STALL);
                    open_left  = $urandom_range(0, 3);
                end
                default:
                begin
                    stall_left = $urandom_range(0, 2);
                    open_left  = $urandom_range(1, 6);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        pix_acc <= rst_n && pixel_valid && !pixel_stall;
        if (rst_n && color_valid && !color_stall)
        begin
            color_cnt++;
            if (color_q.size() == 0)
            begin
                $error("color item with no pixel pending");
                fail_cnt++;
            end
            else
            begin
                want = color_q.pop_front();
                check_field("red", want.red, red);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
                check_field("inside_set", want.in_set, inside_set);
                check_field("escape_count", want.esc, escape_count);
            end
        end
        if (rst_n && pixel_valid && !pixel_stall)
            color_q.push_back(colorize(pixel_x, pixel_y));
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_budget)
        begin
            $display("mandelbrot_pixel_colorizer regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned zoom, lim;
        int          cre, cim;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default window: corners, center of the set, points that fall back onto c
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(512, 512);
        queue_pixel(384, 512);
        queue_pixel(640, 512);
        queue_pixel(0, 512);
        queue_pixel(700, 300);

        // zero zoom: every pixel is the center point
        set_window(0, 32'sh0400_0000, 0, 20);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);

        // zero limit: always inside
        set_window(1 << 20, -134217728, 0, 0);
        queue_pixel(0, 0);
        queue_pixel(512, 512);

        // largest zoom and extreme centers, c saturates
        set_window(32'h7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(512, 512);
        queue_pixel(511, 0);

        set_window(1, 32'sh7fff_ffff, 32'sh8000_0000, 5);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);

        // largest limit, only points that settle quickly
        set_window(1, 0, 0, 65535);
        queue_pixel(512, 512);
        queue_pixel(513, 512);
        queue_pixel(0, 0);

        set_window(1 << 28, 0, 0, 65535);
        queue_pixel(513, 512);
        queue_pixel(1023, 1023);
        queue_pixel(511, 512);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       zoom = $urandom_range(1, 32'h7fff_ffff);
                1:       zoom = $urandom_range(1, 4096);
                default: zoom = $urandom_range(1 << 17, 1 << 21);
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                cre = $urandom;
                cim = $urandom;
            end
            else
            begin
                // keep the window over the interesting part of the plane
                cre = int'($urandom_range(0, 5 << 27)) - (1 << 29);
                cim = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            end
            lim = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 320)
                                              : $urandom_range(1, 64);
            set_window(zoom, cre, cim, lim);
            for (int i = 0; i < RAND_ITEMS; i++)
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            if (ph == 2)
                hold_reqs++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (color_q.size() != 0)
        begin
            $error("%0d colors never arrived", color_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("mandelbrot_pixel_colorizer regression: pass");
        else
            $display("mandelbrot_pixel_colorizer regression: fail");
        $finish;
    end

endmodule
